// ===== rtl/bba_pkg.sv =====
package bba_pkg;

    // Pool geometry.
    localparam int BLOCK_COUNT = 64;
    localparam int BLOCK_BYTES = 32;

    // The occupancy map is kept as words of WORD_BITS blocks each.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = WORD_AW + BIT_W;

    // Bits of the last word that lie past the end of the pool always read as used.
    localparam int LAST_BITS = BLOCK_COUNT - (MAP_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] PAD_MASK =
        WORD_BITS'(~((64'd1 << LAST_BITS) - 64'd1));

    // Byte extent of the pool and the width of an offset inside it.
    localparam int POOL_EXTENT = BLOCK_COUNT * BLOCK_BYTES;
    localparam int OFF_W       = (POOL_EXTENT > 1) ? $clog2(POOL_EXTENT) : 1;

    // Offset to block index by reciprocal multiplication. With the shift set
    // to OFF_W plus the ceiling log2 of the block size, the rounded-up
    // reciprocal gives the exact quotient for every offset below 2**OFF_W.
    localparam int DIV_L  = $clog2(BLOCK_BYTES);
    localparam int DIV_SH = OFF_W + DIV_L;
    localparam int DIV_MW = OFF_W + 2;
    localparam logic [DIV_MW-1:0] DIV_M =
        DIV_MW'(((64'd1 << DIV_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
    localparam int PROD_W = OFF_W + DIV_MW;

    // Result status codes.
    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    // Requests from the controller to the map storage.
    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] word;
    } map_rd_t;

    typedef struct packed {
        logic                 en;
        logic [WORD_AW-1:0]   word;
        logic [WORD_BITS-1:0] data;
    } map_wr_t;

    // Position of the lowest clear bit of a map word.
    function automatic logic [BIT_W-1:0] first_zero_bit(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // Lowest map word that still has a free block.
    function automatic logic [WORD_AW-1:0] first_open_word(input logic [MAP_WORDS-1:0] f);
        logic [WORD_AW-1:0] r;
        r = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--) begin
            if (!f[i]) begin
                r = WORD_AW'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/bba_map.sv =====
module bba_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bba_pkg::map_rd_t                  rd,
    input  bba_pkg::map_wr_t                  wr,
    output logic [bba_pkg::WORD_BITS-1:0]     rd_data,
    output logic [bba_pkg::MAP_WORDS-1:0]     full_flags
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] mem_q_reg;
    logic [MAP_WORDS-1:0] valid_reg;
    logic [MAP_WORDS-1:0] full_reg;
    logic                 rd_valid_reg;
    logic                 rd_last_reg;

    // Storage itself: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.word] <= wr.data;
        end
        if (rd.en) begin
            mem_q_reg <= mem[rd.word];
        end
    end

    // A word never written since reset reads as all free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            full_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.word] <= 1'b1;
                full_reg[wr.word]  <= &(wr.data | ((wr.word == WORD_AW'(MAP_WORDS - 1)) ?
                                                   PAD_MASK : '0));
            end
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.word];
                rd_last_reg  <= (rd.word == WORD_AW'(MAP_WORDS - 1));
            end
        end
    end

    assign rd_data    = (rd_valid_reg ? mem_q_reg : '0) | (rd_last_reg ? PAD_MASK : '0);
    assign full_flags = full_reg;

endmodule

// ===== rtl/bitmap_block_allocator_top.sv =====
// Fixed-size block allocator over a pool of equal blocks.
//
// Requests arrive as beats on the s_ channel. s_tuser selects the request: 0 allocates the
// lowest-numbered free block, 1 frees the block that holds the byte address on s_tdata
// (unaligned addresses round down to their block). Every request produces exactly one result
// beat on the m_ channel: m_tuser carries the status and m_tdata the start address of an
// allocated block, or zero for every other status. The pool's start address is written through
// the cfg_ channel, which is always ready; write it only while no request is in flight.
//
// An allocate or a valid free goes through the read-modify-write of the
// occupancy map word plus a state for the address multiply (allocate)
// or the offset-to-index reciprocal multiply (free) before its result is
// registered. A full pool or an address outside the pool answers straight
// from the idle state. One request is in flight at a time: a new one is
// taken only back in the idle state, after the last result is registered.
//
// Reset clears the whole map to free through per-word valid flags, so the
// block is ready as soon as reset is released. When the receiver stalls,
// the result holds in the output register and no new request is accepted.
module bitmap_block_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Pool base configuration.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,      // pool_base
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // address
    input  logic [0:0]  s_tuser,       // kind
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // block_address
    output logic [1:0]  m_tuser        // status
);
    import bba_pkg::*;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALLOC = 5'b00010,
        S_ADDR  = 5'b00100,
        S_DIV   = 5'b01000,
        S_FREE  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [31:0]          base_reg;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [31:0]          out_addr_reg, out_addr_next;

    map_rd_t              map_rd;
    map_wr_t              map_wr;
    logic [WORD_BITS-1:0] map_rdata;
    logic [MAP_WORDS-1:0] map_full;

    logic                 s_accept;
    logic [31:0]          offset;
    logic                 in_pool;
    logic [BIT_W-1:0]     free_bit;
    logic [PROD_W-1:0]    div_prod;
    logic [IDX_W-1:0]     div_idx;

    bba_map u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd         (map_rd),
        .wr         (map_wr),
        .rd_data    (map_rdata),
        .full_flags (map_full)
    );

    // The block takes a request only when idle and the output register is
    // empty or being emptied in this cycle.
    assign s_tready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Pool range test on the wrapped offset from the pool base.
    assign offset  = s_tdata - base_reg;
    assign in_pool = (offset < 32'(POOL_EXTENT));

    assign free_bit = first_zero_bit(map_rdata);
    assign div_prod = PROD_W'(off_reg) * PROD_W'(DIV_M);
    assign div_idx  = IDX_W'(div_prod >> DIV_SH);

    always_comb begin
        state_next      = state_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        map_rd          = '0;
        map_wr          = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (!s_tuser[0]) begin
                        if (&map_full) begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_FULL;
                            out_addr_next   = '0;
                        end else begin
                            // Fetch the lowest word that still has a free block.
                            map_rd.en   = 1'b1;
                            map_rd.word = first_open_word(map_full);
                            idx_next    = {first_open_word(map_full), {BIT_W{1'b0}}};
                            state_next  = S_ALLOC;
                        end
                    end else begin
                        if (in_pool) begin
                            off_next   = offset[OFF_W-1:0];
                            state_next = S_DIV;
                        end else begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_OUTSIDE;
                            out_addr_next   = '0;
                        end
                    end
                end
            end
            S_ALLOC: begin
                // Mark the lowest free block of the fetched word as used.
                map_wr.en   = 1'b1;
                map_wr.word = idx_reg[IDX_W-1:BIT_W];
                map_wr.data = map_rdata | (WORD_BITS'(1) << free_bit);
                idx_next    = {idx_reg[IDX_W-1:BIT_W], free_bit};
                state_next  = S_ADDR;
            end
            S_ADDR: begin
                out_valid_next  = 1'b1;
                out_status_next = ST_ALLOCATED;
                out_addr_next   = base_reg + 32'(idx_reg) * 32'(BLOCK_BYTES);
                state_next      = S_IDLE;
            end
            S_DIV: begin
                // The quotient addresses the map word read for the free.
                idx_next    = div_idx;
                map_rd.en   = 1'b1;
                map_rd.word = div_idx[IDX_W-1:BIT_W];
                state_next  = S_FREE;
            end
            S_FREE: begin
                map_wr.en       = 1'b1;
                map_wr.word     = idx_reg[IDX_W-1:BIT_W];
                map_wr.data     = map_rdata & ~(WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
                out_valid_next  = 1'b1;
                out_status_next = ST_FREED;
                out_addr_next   = '0;
                state_next      = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                base_reg <= cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        off_reg        <= off_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    // Only an allocation returns a nonzero address.
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != ST_ALLOCATED) |-> (out_addr_reg == '0))
        else $error("nonzero address on a result other than an allocation");

    // While a request is being worked on, the output register is empty.
    a_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("output register busy while a request is in flight");

    // The map is only written in the two write-back states.
    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        map_wr.en |-> (state_reg == S_ALLOC || state_reg == S_FREE))
        else $error("map write outside a write-back state");

    // The word fetched for an allocation must hold a free block.
    a_alloc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC) |-> !(&map_rdata))
        else $error("allocation fetched a full map word");

endmodule

// ===== verif/tb_bitmap_block_allocator_top.sv =====
module tb_bitmap_block_allocator_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    // Request kinds as they travel on s_tuser.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Run length guard in clock cycles. The slowest correct run stays inside it:
    // every request waiting out the longest sender gap, the allocator's
    // turnaround and the longest receiver stall, plus one long receiver hold.
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int TAIL_CYCLES   = 8;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
    } alloc_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
    } alloc_result_t;

    // Every input starts at a known value; reset is held low from time zero.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // address
    logic [0:0]  s_tuser   = '0;     // kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // block_address
    logic [1:0]  m_tuser;            // status

    bitmap_block_allocator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Requests waiting to be driven, and the replies the allocator owes us.
    alloc_request_t pending_requests[$];
    alloc_result_t  owed_replies[$];

    // Our own copy of the allocator: the occupancy bitmap and the pool base.
    logic [BLOCK_COUNT-1:0] block_used = '0;
    logic [31:0]            base_model = '0;

    int unsigned cycle_count = 0;
    int          error_count = 0;
    int          status_tally[4];
    int          replies_checked = 0;
    int          base_writes = 0;

    // Handshake flags, written only at the rising edge and read at the falling one.
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;

    // Idle shaping, set per phase by the sequencer.
    int tx_gap_max   = 0;
    int rx_stall_max = 0;
    int hold_orders  = 0;

    // Serve one request against the local bitmap and return the reply the
    // allocator must give. Allocation takes the lowest free block; a free
    // clears the block holding the address if it lies inside the pool,
    // where the pool may wrap past the top of the 32-bit address space.
    function automatic alloc_result_t serve_request(input logic kind,
                                                    input logic [31:0] addr);
        alloc_result_t r;
        logic [31:0]   offset;
        int            idx;
        r.status        = ST_FULL;
        r.block_address = '0;
        if (kind == KIND_ALLOC) begin
            for (idx = 0; idx < BLOCK_COUNT; idx++) begin
                if (!block_used[idx]) begin
                    block_used[idx] = 1'b1;
                    r.status        = ST_ALLOCATED;
                    r.block_address = base_model + 32'(idx * BLOCK_BYTES);
                    break;
                end
            end
        end else begin
            offset = addr - base_model;
            if (offset < 32'(POOL_EXTENT)) begin
                // A double free lands here too and simply leaves the bit clear.
                block_used[offset / 32'(BLOCK_BYTES)] = 1'b0;
                r.status = ST_FREED;
            end else begin
                r.status = ST_OUTSIDE;
            end
        end
        status_tally[r.status]++;
        return r;
    endfunction

    // Rising-edge monitor. Outputs are sampled here, before the allocator's own
    // register updates land, and every accepted beat is acted on: a config
    // beat updates the pool base, a request beat queues its reply, and a
    // result beat is compared field by field with the oldest owed reply.
    alloc_result_t want;

    always @(posedge aclk) begin
        cycle_count++;
        req_taken = aresetn && s_tvalid && s_tready;
        res_taken = aresetn && m_tvalid && m_tready;
        if (aresetn && cfg_valid && cfg_ready) begin
            base_model = cfg_data;
            base_writes++;
        end
        if (req_taken) begin
            owed_replies.push_back(serve_request(s_tuser[0], s_tdata));
        end
        if (res_taken) begin
            if (owed_replies.size() == 0) begin
                error_count++;
                $display("%0t: result beat with no reply owed, status %0d address %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = owed_replies.pop_front();
                replies_checked++;
                if (m_tuser !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata !== want.block_address) begin
                    error_count++;
                    $display("%0t: block address mismatch, expected %h, actual %h",
                             $time, want.block_address, m_tdata);
                end
            end
        end
    end

    // Request driver. After each accepted beat it draws an idle gap; once
    // the gap has run out it presents the next queued request. Valid stays
    // high across back-to-back beats with a single assignment per edge.
    int             req_gap = 0;
    alloc_request_t next_req;

    always @(negedge aclk) begin
        if (req_taken) begin
            req_gap = $urandom_range(0, tx_gap_max);
        end
        if (!s_tvalid || req_taken) begin
            if (req_gap == 0 && pending_requests.size() != 0) begin
                next_req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_req.address;
                s_tuser  <= next_req.kind;
            end else begin
                if (req_gap != 0) begin
                    req_gap--;
                end
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver. It stalls for a drawn number of cycles after each
    // beat it takes. When the sequencer orders a long hold, the receiver
    // counts it down here, which backs the allocator up into its input.
    int rx_wait     = 0;
    int hold_left   = 0;
    int hold_served = 0;

    always @(negedge aclk) begin
        if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left   = HOLD_CYCLES;
        end
        if (res_taken) begin
            rx_wait = $urandom_range(0, rx_stall_max);
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_pool_base(input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic queue_request(input logic kind, input logic [31:0] addr);
        alloc_request_t r;
        r.kind    = kind;
        r.address = addr;
        pending_requests.push_back(r);
    endtask

    // Random requests for one phase. Most frees hit a block of the pool,
    // aligned or not; the rest probe both pool edges, the bytes just past
    // them, and arbitrary addresses. Allocations carry junk addresses.
    task automatic queue_random_phase(input logic [31:0] base, input int count,
                                      input int alloc_pct);
        logic [31:0] addr;
        int          sel;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1, 100) <= alloc_pct) begin
                queue_request(KIND_ALLOC, $urandom());
            end else begin
                sel = $urandom_range(0, 9);
                if (sel <= 5) begin
                    addr = base + 32'($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES);
                    if ($urandom_range(0, 1) == 1) begin
                        addr = addr + 32'($urandom_range(0, BLOCK_BYTES - 1));
                    end
                end else if (sel == 6) begin
                    addr = base + 32'(POOL_EXTENT) + 32'($urandom_range(0, 255));
                end else if (sel == 7) begin
                    addr = base - 32'd1 - 32'($urandom_range(0, 255));
                end else if (sel == 8) begin
                    addr = ($urandom_range(0, 1) == 1) ? base + 32'(POOL_EXTENT - 1) : base;
                end else begin
                    addr = $urandom();
                end
                queue_request(KIND_FREE, addr);
            end
        end
    endtask

    // Wait until every queued request has been driven and every reply has
    // come back, then give the allocator time to settle.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || owed_replies.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Timeout: a run that has not finished by the limit counts as failed.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d replies still owed", $time, owed_replies.size());
        $display("bitmap_block_allocator_top regression: fail");
        $finish;
    end

    // Sequencer: reset, a directed phase at pool base zero, then random
    // phases at different pool bases and idle patterns. The pool base is
    // only rewritten while the allocator is drained. The bitmap carries over
    // between phases, just as the allocator keeps its blocks across a base
    // change.
    logic [31:0] phase_base;

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_pool_base(32'h0000_0000);

        // Directed: allocate twice, free block 0 and reallocate it as the
        // lowest free block, an unaligned free, a double free, the last byte
        // of the pool, the first byte past it, the top of the address
        // space, and allocations whose ignored address is all ones or mixed.
        queue_request(KIND_ALLOC, 32'h0000_0000);
        queue_request(KIND_ALLOC, 32'h0000_0000);
        queue_request(KIND_FREE,  32'h0000_0000);
        queue_request(KIND_ALLOC, 32'h0000_0000);
        queue_request(KIND_FREE,  32'd37);
        queue_request(KIND_FREE,  32'd37);
        queue_request(KIND_FREE,  32'(POOL_EXTENT - 1));
        queue_request(KIND_FREE,  32'(POOL_EXTENT));
        queue_request(KIND_FREE,  32'hFFFF_FFFF);
        queue_request(KIND_FREE,  32'h0000_0000);
        queue_request(KIND_ALLOC, 32'hFFFF_FFFF);
        queue_request(KIND_ALLOC, 32'hAAAA_AAAA);
        queue_request(KIND_ALLOC, 32'h5555_5555);
        queue_request(KIND_FREE,  32'd95);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       phase_base = 32'hFFFF_FFFF;
                1:       phase_base = 32'hFFFF_FC00;   // pool wraps past the top
                3:       phase_base = 32'h8000_0000;
                7:       phase_base = 32'h0000_0000;
                default: phase_base = $urandom();
            endcase
            write_pool_base(phase_base);

            case ($urandom_range(0, 2))
                0:       tx_gap_max = 0;
                1:       tx_gap_max = 4;
                default: tx_gap_max = 14;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_stall_max = 0;
                1:       rx_stall_max = 4;
                default: rx_stall_max = 14;
            endcase
            if (phase == 1) begin
                tx_gap_max   = 0;
                rx_stall_max = 0;
            end else if (phase == 4) begin
                tx_gap_max   = 14;
                rx_stall_max = 14;
            end

            if (phase == 2) begin
                // Back pressure: the receiver holds off while a burst of
                // allocations that overruns the pool is offered without gaps.
                tx_gap_max = 0;
                hold_orders++;
                for (int n = 0; n < BLOCK_COUNT + 6; n++) begin
                    queue_request(KIND_ALLOC, $urandom());
                end
            end
            queue_random_phase(phase_base, PHASE_ITEMS, $urandom_range(35, 85));
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d replies over %0d pool base writes: %0d allocated, %0d pool full,",
                 replies_checked, base_writes, status_tally[ST_ALLOCATED],
                 status_tally[ST_FULL]);
        $display("%0d freed, %0d outside the pool, with one %0d-cycle receiver hold.",
                 status_tally[ST_FREED], status_tally[ST_OUTSIDE], HOLD_CYCLES);
        if (error_count == 0 && owed_replies.size() == 0) begin
            $display("bitmap_block_allocator_top regression: pass");
        end else begin
            $display("bitmap_block_allocator_top regression: fail");
        end
        $finish;
    end

endmodule
